// ===== hdl/nre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nre_pkg: shared types and constants for the number record encoder
// Tags, field widths and the classified record handed to the serializer.
// ----------------------------------------------------------------------------
package nre_pkg;

	localparam logic [7:0] TAG_INT = 8'd3;
	localparam logic [7:0] TAG_NUM = 8'd4;
	localparam int unsigned MANT_BITS = 52;
	localparam logic [10:0] EXP_BIAS = 11'd1023;
	localparam logic [10:0] EXP_LIMIT = 11'd1076; // bias + 53
	localparam logic [10:0] EXP_MAX = 11'h7ff;

	// classified record: payload is zigzag code (int) or raw pattern
	typedef struct packed {
		logic        is_int;
		logic [3:0]  nbytes;   // payload bytes, 1..8
		logic [63:0] payload;
	} rec_t;

endpackage

// ===== hdl/nre_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nre_classify: integer check and zigzag mapping
// Combinational: decides record kind and computes payload and byte count.
// ----------------------------------------------------------------------------
module nre_classify (
	input  logic [63:0]  double_bits,
	output nre_pkg::rec_t rec
);
	import nre_pkg::*;

	logic        sign;
	logic [10:0] expo;
	logic [51:0] mant;
	logic [5:0]  frac_bits;
	logic [51:0] frac_mask;
	logic [53:0] mag;
	logic [63:0] zz;
	logic        ok;
	logic [3:0]  nb;

	assign sign = double_bits[63];
	assign expo = double_bits[62:52];
	assign mant = double_bits[51:0];

	always_comb begin
		ok = 1'b0;
		frac_bits = 6'd0;
		frac_mask = '0;
		mag = '0;
		if (expo == 11'd0) begin
			ok = (mant == '0) && !sign;
		end else if (expo != EXP_MAX && expo >= EXP_BIAS && expo <= EXP_LIMIT) begin
			if (expo == EXP_LIMIT) begin
				ok = (mant == '0);
				mag = 54'd1 << 53;
			end else begin
				frac_bits = 6'(EXP_LIMIT - 11'd1 - expo);
				frac_mask = (52'd1 << frac_bits) - 52'd1;
				ok = (mant & frac_mask) == '0;
				mag = {2'b01, mant} >> frac_bits;
			end
		end
		zz = sign ? (({9'd0, mag, 1'b0}) - 64'd1) : {9'd0, mag, 1'b0};
		// varint length: one byte, plus one per 7-bit group above the first up to the highest nonzero one
		nb = 4'd1;
		for (int k = 1; k < 8; k++) begin
			if ((zz >> (7 * k)) != 64'd0) nb = nb + 4'd1;
		end
		rec.is_int = ok;
		if (ok) begin
			rec.payload = zz;
			rec.nbytes = nb;
		end else begin
			rec.payload = double_bits;
			rec.nbytes = 4'd8;
		end
	end

endmodule

// ===== hdl/nre_serial.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nre_serial: byte serializer
// Holds one record and emits tag, then payload bytes, marking the last word.
// ----------------------------------------------------------------------------
module nre_serial (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  nre_pkg::rec_t rec,
	output logic          busy,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast
);
	import nre_pkg::*;

	logic        valid_q;
	logic        is_int_q;
	logic [3:0]  left_q;   // payload bytes still to send after current
	logic        tag_q;    // current word is the tag
	logic [63:0] sh_q;
	logic        adv;

	assign m_tvalid = valid_q;
	assign adv      = valid_q && m_tready;
	assign m_tlast  = !tag_q && (left_q == 4'd0);
	// ready for a new record when idle or on the final accepted word
	assign busy     = valid_q && !(m_tready && m_tlast);

	always_comb begin
		if (tag_q)
			m_tdata = is_int_q ? TAG_INT : TAG_NUM;
		else if (is_int_q)
			m_tdata = {left_q != 4'd0, sh_q[6:0]};
		else
			m_tdata = sh_q[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tag_q   <= 1'b0;
			left_q  <= 4'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			tag_q   <= 1'b1;
			left_q  <= rec.nbytes;
		end else if (adv) begin
			if (m_tlast) valid_q <= 1'b0;
			tag_q  <= 1'b0;
			if (!tag_q) left_q <= left_q - 4'd1;
			else        left_q <= left_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			is_int_q <= rec.is_int;
			sh_q     <= rec.payload;
		end else if (adv && !tag_q) begin
			sh_q <= is_int_q ? {7'd0, sh_q[63:7]} : {8'd0, sh_q[63:8]};
		end
	end

endmodule

// ===== hdl/number_record_encoder.sv =====
`timescale 1ns / 1ps
// First output word: the serializer registers it on loading the record from the input register.
// Throughput: 2 to 9 output words per number (tag plus 1..8 payload bytes); the
// byte-wide output channel sets the rate, and the next number is classified
// while the current one is still being sent.
// Reset: arst_n clears all valid and count state; payload registers are not reset.
// ----------------------------------------------------------------------------
// number_record_encoder: double to tagged varint or raw byte record
// Input register and classifier feeding a byte serializer that holds the record.
// ----------------------------------------------------------------------------
module number_record_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] double_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast    // last_byte
);
	import nre_pkg::*;

	logic          in_valid_s1;
	logic [63:0]   in_bits_s1;
	nre_pkg::rec_t rec_s1;
	logic          busy;
	logic          load;

	assign load     = in_valid_s1 && !busy;
	assign s_tready = !in_valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) in_bits_s1 <= s_tdata;
	end

	nre_classify u_cls (
		.double_bits (in_bits_s1),
		.rec         (rec_s1)
	);

	nre_serial u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.rec      (rec_s1),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== hdl/nre_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nre_checker: port-level checks for the number record encoder
// Record framing, output hold under stall and output after input, bound to the top level.
// ----------------------------------------------------------------------------
module nre_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);
	import nre_pkg::*;

	logic first_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b1;
		else if (m_tvalid && m_tready) first_q <= m_tlast;
	end

	a_tag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q |-> (m_tdata == TAG_INT || m_tdata == TAG_NUM))
		else $error("record does not start with a tag");

	a_tag_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q |-> !m_tlast)
		else $error("tag marked last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// output goes valid from idle only after an input word was taken and loaded into the serializer
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output word without input");

endmodule

bind number_record_encoder nre_checker u_nre_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/tb_number_record_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_number_record_encoder: self-checking bench for the number record encoder
// Drives binary64 patterns (directed table, then random classes of integers,
// fractions and specials) and checks every output byte and its last flag
// against an in-bench encoder of the integer/raw record format.
// ----------------------------------------------------------------------------
module tb_number_record_encoder;
	import nre_pkg::*;

	localparam int N_RANDOM = 400;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_exp_t;

	typedef struct {
		logic [63:0] bits;
		int          nexp;      // 0 means no typed-in expectation
		logic [7:0]  exp0;
		logic [7:0]  exp1;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	byte_exp_t record_q[$];
	int        errors;
	longint    cycles;
	bit        no_idle;

	number_record_encoder DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// integer check on sign/exponent/mantissa, then zigzag
	function automatic bit int_zigzag(input logic [63:0] bits, output logic [63:0] zz);
		logic        sgn;
		logic [10:0] ex;
		logic [51:0] man;
		logic [63:0] mag;
		logic [63:0] fmask;
		int          frac;
		sgn = bits[63];
		ex = bits[62:52];
		man = bits[51:0];
		zz = '0;
		if (ex == 11'd0) return (man == '0 && !sgn);
		if (ex == EXP_MAX || ex < EXP_BIAS || ex > EXP_LIMIT) return 0;
		if (ex == EXP_LIMIT) begin
			if (man != '0) return 0;
			mag = 64'd1 << 53;
		end else begin
			frac = 52 - int'(ex - EXP_BIAS);
			fmask = (64'd1 << frac) - 64'd1;
			if ((64'(man) & fmask) != '0) return 0;
			mag = ({12'd1, man}) >> frac;
		end
		zz = sgn ? ((mag << 1) - 64'd1) : (mag << 1);
		return 1;
	endfunction

	task automatic predict_record(input logic [63:0] bits);
		logic [63:0] zz;
		byte_exp_t   b;
		if (int_zigzag(bits, zz)) begin
			b.data = TAG_INT; b.last = 1'b0; record_q.push_back(b);
			do begin
				b.data = {1'b0, zz[6:0]};
				zz = zz >> 7;
				if (zz != '0) b.data[7] = 1'b1;
				b.last = (zz == '0);
				record_q.push_back(b);
			end while (zz != '0);
		end else begin
			b.data = TAG_NUM; b.last = 1'b0; record_q.push_back(b);
			for (int i = 0; i < 8; i++) begin
				b.data = bits[8*i +: 8];
				b.last = (i == 7);
				record_q.push_back(b);
			end
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random pattern biased toward integers at every exponent from bias to bias + 53
	function automatic logic [63:0] rand_number();
		logic [63:0] v;
		int          k;
		int          sel;
		v = rand64();
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			k = $urandom_range(0, 53);
			v[62:52] = EXP_BIAS + 11'(k);
			if (k < 52) v[51:0] = v[51:0] & ~((52'd1 << (52 - k)) - 52'd1);
			if (k == 53 && $urandom_range(0, 1)) v[51:0] = '0;
		end else if (sel == 5) begin
			v[62:52] = EXP_BIAS + 11'($urandom_range(0, 53));   // likely fraction
		end else if (sel == 6) begin
			v[62:52] = $urandom_range(0, 1) ? EXP_MAX : 11'd0;
			if ($urandom_range(0, 2) == 0) v[51:0] = '0;
		end else if (sel == 7) begin
			v[62:52] = EXP_LIMIT + 11'($urandom_range(1, 20));
		end
		return v;
	endfunction

	// called at a falling edge; leaves tvalid high for a following word
	task automatic send_number(input logic [63:0] bits);
		while (!no_idle && $urandom_range(0, 99) < 27) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= bits;
		do @(posedge clk); while (!s_tready);
		predict_record(bits);
		@(negedge clk);
	endtask

	// output side: random stalls (none while no_idle is set), sampled at the rising edge
	always @(negedge clk)
		m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 27);

	always @(posedge clk) begin
		byte_exp_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (record_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word data=%02h last=%b", $time, m_tdata, m_tlast);
			end else begin
				e = record_q.pop_front();
				if (m_tdata !== e.data || m_tlast !== e.last) begin
					errors++;
					$display("%0t: mismatch expected data=%02h last=%b actual data=%02h last=%b",
						$time, e.data, e.last, m_tdata, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("number_record_encoder verification failed");
			$finish;
		end
	end

	// directed rows; first two bytes typed in where obvious
	dir_row_t dir_tab[] = '{
		'{64'h0000_0000_0000_0000, 2, TAG_INT, 8'h00},   // +0
		'{64'h8000_0000_0000_0000, 1, TAG_NUM, 8'h00},   // -0 keeps raw
		'{64'h3FF0_0000_0000_0000, 2, TAG_INT, 8'h02},   // 1.0
		'{64'hBFF0_0000_0000_0000, 2, TAG_INT, 8'h01},   // -1.0
		'{64'h7FF0_0000_0000_0000, 1, TAG_NUM, 8'h00},   // +inf
		'{64'hFFF0_0000_0000_0000, 1, TAG_NUM, 8'h00},   // -inf
		'{64'h7FF8_0000_0000_0001, 1, TAG_NUM, 8'h01},   // NaN payload
		'{64'hFFFF_FFFF_FFFF_FFFF, 1, TAG_NUM, 8'hFF},
		'{64'h0000_0000_0000_0001, 1, TAG_NUM, 8'h01},   // min subnormal
		'{64'h000F_FFFF_FFFF_FFFF, 1, TAG_NUM, 8'hFF},   // max subnormal
		'{64'h3FE0_0000_0000_0000, 1, TAG_NUM, 8'h00},   // 0.5
		'{64'h3FF8_0000_0000_0000, 1, TAG_NUM, 8'h00},   // 1.5
		'{64'h4340_0000_0000_0000, 0, 8'h00, 8'h00},     // +2^53
		'{64'hC340_0000_0000_0000, 0, 8'h00, 8'h00},     // -2^53
		'{64'h4340_0000_0000_0001, 1, TAG_NUM, 8'h01},   // 2^53 + 2
		'{64'h433F_FFFF_FFFF_FFFF, 0, 8'h00, 8'h00},     // 2^53 - 1
		'{64'hC33F_FFFF_FFFF_FFFF, 0, 8'h00, 8'h00},
		'{64'h4350_0000_0000_0000, 1, TAG_NUM, 8'h00},   // 2^54
		'{64'h4050_0000_0000_0000, 0, 8'h00, 8'h00},     // 64, two varint bytes
		'{64'hC050_0000_0000_0000, 0, 8'h00, 8'h00},     // -64
		'{64'h7FEF_FFFF_FFFF_FFFF, 1, TAG_NUM, 8'hFF}    // max finite
	};

	initial begin
		errors = 0;
		cycles = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			send_number(dir_tab[i].bits);
			// typed-in check of the leading bytes on top of the prediction
			if (dir_tab[i].nexp > 0) begin
				byte_exp_t hd[$];
				hd = record_q[$-((dir_tab[i].nexp == 2) ? 1 : 8) : $];
				if (hd[0].data !== dir_tab[i].exp0 ||
					(dir_tab[i].nexp == 2 && hd[1].data !== dir_tab[i].exp1) ||
					(dir_tab[i].nexp == 1 && hd[1].data !== dir_tab[i].exp1)) begin
					errors++;
					$display("%0t: mismatch expected %02h %02h actual prediction %02h %02h",
						$time, dir_tab[i].exp0, dir_tab[i].exp1, hd[0].data, hd[1].data);
				end
			end
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			no_idle = (n >= 150 && n < 230);
			send_number((n % 20 == 0) ? rand64() : rand_number());
		end
		no_idle = 1'b0;
		s_tvalid <= 1'b0;

		while (record_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("number_record_encoder verification clean");
		else
			$display("number_record_encoder verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/nre_pkg.sv
hdl/nre_classify.sv
hdl/nre_serial.sv
hdl/number_record_encoder.sv
hdl/nre_checker.sv
tb/tb_number_record_encoder.sv
